### sv/irt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package irt_pkg;

    localparam logic [1:0] STATUS_BOOKED  = 2'd0;
    localparam logic [1:0] STATUS_OVERLAP = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;
    localparam logic [1:0] STATUS_INVALID = 2'd3;

    localparam int IN_DATA_BITS  = 64;
    localparam int OUT_DATA_BITS = 8;
    localparam int FIELD_BITS    = 32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } irt_state_t;

    typedef struct packed {
        logic load;
        logic scan_issue;
        logic finish;
    } irt_cmd_t;

    typedef struct packed {
        logic invalid;
        logic scan_done;
        logic out_busy;
    } irt_stat_t;

endpackage

`default_nettype wire

### sv/interval_reservation_table.sv
// Booking table for half-open time intervals [start, end).
// The slave stream carries one request per transfer; s_tdata holds start_time
// in bits 31:0 and end_time in bits 63:32. The master stream returns exactly
// one result per request; m_tdata holds accepted in bit 0 and status in bits
// 2:1 (booked, overlap, table full, invalid).
// A request is stored when end is above start, it overlaps no stored
// interval and the table has room. Intervals that only touch do not overlap.
// A result is formed once a single comparator pair has walked the table
// memory one entry per cycle over the N stored intervals; an invalid
// request skips the walk. The next request is taken in the cycle after
// a result is issued, so the block takes no new request while one is in
// progress. With the default depth a full table holds 64 entries.
// Reset empties the table at once; entry contents need no clearing because
// only entries below the fill count are read.
// When the receiver stalls, a finished result waits in the output register
// and the block still accepts and scans the next request; it then holds
// that request's result until the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module interval_reservation_table #(
    parameter int MAX_INTERVALS = 64,
    parameter int TIME_BITS     = 32
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    // Fields from bit 0: start_time[31:0], end_time[63:32].
    input  wire [irt_pkg::IN_DATA_BITS-1:0]   s_tdata,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // Fields from bit 0: accepted[0], status[2:1], zero padding[7:3].
    output logic [irt_pkg::OUT_DATA_BITS-1:0] m_tdata
);
    import irt_pkg::*;

    irt_cmd_t  cmd;
    irt_stat_t stat;

    irt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    irt_datapath #(
        .MAX_INTERVALS (MAX_INTERVALS),
        .TIME_BITS     (TIME_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

`default_nettype wire

### sv/irt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module irt_ctrl (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               s_tvalid,
    output logic              s_tready,
    input  irt_pkg::irt_stat_t stat,
    output irt_pkg::irt_cmd_t  cmd
);
    import irt_pkg::*;

    irt_state_t state_reg;
    irt_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        s_tready       = 1'b0;
        cmd.load       = 1'b0;
        cmd.scan_issue = 1'b0;
        cmd.finish     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.invalid || stat.scan_done)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.scan_issue = 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/irt_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module irt_datapath #(
    parameter int MAX_INTERVALS = 64,
    parameter int TIME_BITS     = 32
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire [irt_pkg::IN_DATA_BITS-1:0]      s_tdata,
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    output logic [irt_pkg::OUT_DATA_BITS-1:0]    m_tdata,
    input  irt_pkg::irt_cmd_t                    cmd,
    output irt_pkg::irt_stat_t                   stat
);
    import irt_pkg::*;

    localparam int TB = (TIME_BITS < FIELD_BITS) ? TIME_BITS : FIELD_BITS;
    localparam int CW = $clog2(MAX_INTERVALS + 1);
    localparam int IW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_INTERVALS);

    logic [2*TB-1:0] mem [MAX_INTERVALS];
    logic [2*TB-1:0] rdata_reg;

    logic [TB-1:0]   req_start_reg;
    logic [TB-1:0]   req_end_reg;
    logic [CW-1:0]   rd_idx_reg;
    logic [CW-1:0]   used_reg;
    logic            cmp_valid_reg;
    logic            clash_reg;
    logic            out_valid_reg;
    logic            out_accepted_reg;
    logic [1:0]      out_status_reg;

    logic [TB-1:0]   slot_start;
    logic [TB-1:0]   slot_end;
    logic            hit;
    logic            full;
    logic [1:0]      status_next;

    assign slot_start = rdata_reg[TB-1:0];
    assign slot_end   = rdata_reg[2*TB-1:TB];
    assign hit        = cmp_valid_reg && (req_start_reg < slot_end)
                        && (slot_start < req_end_reg);
    assign full       = (used_reg == MAX_COUNT);

    always_comb
    begin
        if (stat.invalid)
        begin
            status_next = STATUS_INVALID;
        end
        else if (clash_reg)
        begin
            status_next = STATUS_OVERLAP;
        end
        else if (full)
        begin
            status_next = STATUS_FULL;
        end
        else
        begin
            status_next = STATUS_BOOKED;
        end
    end

    // Status bits from the top: invalid, scan_done, out_busy.
    assign stat = {(req_end_reg <= req_start_reg), (rd_idx_reg == used_reg),
                   (out_valid_reg && !m_tready)};

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[rd_idx_reg[IW-1:0]];
        if (cmd.finish && (status_next == STATUS_BOOKED))
        begin
            mem[used_reg[IW-1:0]] <= {req_end_reg, req_start_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_start_reg <= s_tdata[TB-1:0];
            req_end_reg   <= s_tdata[FIELD_BITS+TB-1:FIELD_BITS];
        end
        if (cmd.finish)
        begin
            out_accepted_reg <= (status_next == STATUS_BOOKED);
            out_status_reg   <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg    <= '0;
            used_reg      <= '0;
            cmp_valid_reg <= 1'b0;
            clash_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cmp_valid_reg <= cmd.scan_issue;
            if (cmd.load)
            begin
                rd_idx_reg <= '0;
                clash_reg  <= 1'b0;
            end
            else
            begin
                if (cmd.scan_issue)
                begin
                    rd_idx_reg <= rd_idx_reg + CW'(1);
                end
                if (hit)
                begin
                    clash_reg <= 1'b1;
                end
            end
            if (cmd.finish && (status_next == STATUS_BOOKED))
            begin
                used_reg <= used_reg + CW'(1);
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_BITS-3){1'b0}}, out_status_reg, out_accepted_reg};

endmodule

`default_nettype wire

### sv/irt_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module irt_checker (
    input wire                               clk,
    input wire                               rst_n,
    input wire                               s_tvalid,
    input wire                               s_tready,
    input wire                               m_tvalid,
    input wire                               m_tready,
    input wire [irt_pkg::OUT_DATA_BITS-1:0]  m_tdata
);
    import irt_pkg::*;

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Stalled result changed or dropped.");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[0] == (m_tdata[2:1] == STATUS_BOOKED)))
        else $error("Accepted flag disagrees with status.");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[OUT_DATA_BITS-1:3] == '0))
        else $error("Result padding is not zero.");

    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("Second request taken while one is in progress.");

endmodule

bind interval_reservation_table irt_checker u_irt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
